[hdl/brl_pkg.sv]
`timescale 1ns / 1ps
// brl_pkg: shared constants for the bresenham line rasterizer
// no dependencies; used by bresenham_line_rasterizer_top

package brl_pkg;

   // default sizes of coordinates and color words
   localparam int DEF_COORD_BITS = 12;
   localparam int DEF_COLOR_BITS = 32;

   // canvas width after reset
   localparam int WIDTH_RESET = 640;

   // item modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

endpackage

[hdl/bresenham_line_rasterizer_top.sv]
`timescale 1ns / 1ps
// bresenham_line_rasterizer_top: endpoint setup, error walk and pixel addressing
// depends on brl_pkg for default sizes, reset width and mode codes
//
// pipeline: an accepted item goes to the walk/pixel register, then through the
//   address multiply into the result register
// throughput: one item per cycle unless stalled; walk state updates at accept
// reset: synchronous, clears the line state (idle) and loads canvas width 640

module bresenham_line_rasterizer_top #(
   parameter int COORD_BITS = brl_pkg::DEF_COORD_BITS,
   parameter int COLOR_BITS = brl_pkg::DEF_COLOR_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_wr_en,
   input  logic [COORD_BITS:0]     csr_wr_data,
   // input items
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic [COORD_BITS-1:0]   req_start_x,
   input  logic [COORD_BITS-1:0]   req_start_y,
   input  logic [COORD_BITS-1:0]   req_end_x,
   input  logic [COORD_BITS-1:0]   req_end_y,
   input  logic [COLOR_BITS-1:0]   req_line_color,
   // result items
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [COORD_BITS-1:0]   rsp_pixel_x,
   output logic [COORD_BITS-1:0]   rsp_pixel_y,
   output logic [2*COORD_BITS-1:0] rsp_pixel_address,
   output logic [COLOR_BITS-1:0]   rsp_pixel_color,
   output logic                    rsp_last_pixel
);

   localparam int ERR_BITS = COORD_BITS + 2;
   localparam int CMP_BITS = COORD_BITS + 4;
   localparam int ADDR_BITS = 2 * COORD_BITS;
   localparam int PROD_BITS = 2 * COORD_BITS + 1;

   // configuration register
   logic [COORD_BITS:0] width_ff;

   // walk state
   logic                       busy_ff, busy_in;
   logic [COORD_BITS-1:0]      cur_major_ff, cur_major_in;
   logic [COORD_BITS-1:0]      cur_minor_ff, cur_minor_in;
   logic [COORD_BITS-1:0]      stop_major_ff, stop_major_in;
   logic [COORD_BITS-1:0]      delta_major_ff, delta_major_in;
   logic [COORD_BITS-1:0]      delta_minor_ff, delta_minor_in;
   logic signed [ERR_BITS-1:0] error_term_ff, error_term_in;
   logic                       minor_down_ff, minor_down_in;
   logic                       x_is_major_ff, x_is_major_in;
   logic [COLOR_BITS-1:0]      held_color_ff, held_color_in;

   // pixel stage
   logic                  pix_valid_ff, pix_valid_in;
   logic [COORD_BITS-1:0] pix_x_ff, pix_x_in;
   logic [COORD_BITS-1:0] pix_y_ff, pix_y_in;
   logic [COLOR_BITS-1:0] pix_color_ff, pix_color_in;
   logic                  pix_last_ff, pix_last_in;

   // result register
   logic                  out_valid_ff;
   logic [COORD_BITS-1:0] out_x_ff;
   logic [COORD_BITS-1:0] out_y_ff;
   logic [ADDR_BITS-1:0]  out_addr_ff, out_addr_in;
   logic [COLOR_BITS-1:0] out_color_ff;
   logic                  out_last_ff;

   logic out_load;
   logic pix_load;
   logic req_fire;
   logic is_start;
   logic emits;

   // setup of a new line
   logic [COORD_BITS-1:0] dx, dy;
   logic                  su_x_major;
   logic [COORD_BITS-1:0] su_ma0, su_ma1, su_mi0, su_mi1;
   logic [COORD_BITS-1:0] su_dmaj, su_dmin;
   logic                  su_swap;

   // selected walk values: fresh setup on start, else stored state
   logic [COORD_BITS-1:0]      sel_major, sel_minor, sel_stop, sel_dmaj, sel_dmin;
   logic signed [ERR_BITS-1:0] sel_err;
   logic                       sel_down, sel_x_major;
   logic [COLOR_BITS-1:0]      sel_color;
   logic                       sel_last;

   logic signed [CMP_BITS-1:0] err_sum, err_twice, dmaj_ext, err_minor;
   logic                       minor_step;
   logic [PROD_BITS-1:0]       addr_full;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign pix_load  = !pix_valid_ff || out_load;
   assign req_ready = pix_load;
   assign req_fire  = req_valid && req_ready;
   assign is_start  = (req_mode == brl_pkg::MODE_START);
   assign emits     = req_fire && (is_start || busy_ff);

   always_comb begin
      dx = (req_end_x > req_start_x) ? req_end_x - req_start_x : req_start_x - req_end_x;
      dy = (req_end_y > req_start_y) ? req_end_y - req_start_y : req_start_y - req_end_y;
      // ties and vertical lines walk along y
      su_x_major = dx > dy;
      if (su_x_major) begin
         su_ma0  = req_start_x;
         su_ma1  = req_end_x;
         su_mi0  = req_start_y;
         su_mi1  = req_end_y;
         su_dmaj = dx;
         su_dmin = dy;
      end else begin
         su_ma0  = req_start_y;
         su_ma1  = req_end_y;
         su_mi0  = req_start_x;
         su_mi1  = req_end_x;
         su_dmaj = dy;
         su_dmin = dx;
      end
      su_swap = su_ma0 > su_ma1;
   end

   always_comb begin
      if (is_start) begin
         sel_major   = su_swap ? su_ma1 : su_ma0;
         sel_stop    = su_swap ? su_ma0 : su_ma1;
         sel_minor   = su_swap ? su_mi1 : su_mi0;
         sel_down    = su_swap ? (su_mi0 < su_mi1) : (su_mi1 < su_mi0);
         sel_dmaj    = su_dmaj;
         sel_dmin    = su_dmin;
         sel_err     = '0;
         sel_x_major = su_x_major;
         sel_color   = req_line_color;
      end else begin
         sel_major   = cur_major_ff;
         sel_stop    = stop_major_ff;
         sel_minor   = cur_minor_ff;
         sel_down    = minor_down_ff;
         sel_dmaj    = delta_major_ff;
         sel_dmin    = delta_minor_ff;
         sel_err     = error_term_ff;
         sel_x_major = x_is_major_ff;
         sel_color   = held_color_ff;
      end
      sel_last = (sel_major == sel_stop);
   end

   // error rule: move the minor axis unless 2*(err+dmin) < dmaj
   always_comb begin
      err_sum    = CMP_BITS'(sel_err) + $signed({4'b0, sel_dmin});
      err_twice  = err_sum <<< 1;
      dmaj_ext   = $signed({4'b0, sel_dmaj});
      minor_step = !(err_twice < dmaj_ext);
      err_minor  = err_sum - dmaj_ext;
   end

   always_comb begin
      busy_in        = busy_ff;
      cur_major_in   = cur_major_ff;
      cur_minor_in   = cur_minor_ff;
      stop_major_in  = stop_major_ff;
      delta_major_in = delta_major_ff;
      delta_minor_in = delta_minor_ff;
      error_term_in  = error_term_ff;
      minor_down_in  = minor_down_ff;
      x_is_major_in  = x_is_major_ff;
      held_color_in  = held_color_ff;
      if (emits) begin
         busy_in        = !sel_last;
         cur_major_in   = sel_major;
         cur_minor_in   = sel_minor;
         stop_major_in  = sel_stop;
         delta_major_in = sel_dmaj;
         delta_minor_in = sel_dmin;
         error_term_in  = sel_err;
         minor_down_in  = sel_down;
         x_is_major_in  = sel_x_major;
         held_color_in  = sel_color;
         if (!sel_last) begin
            cur_major_in = sel_major + 1'b1;
            if (minor_step) begin
               cur_minor_in  = sel_down ? sel_minor - 1'b1 : sel_minor + 1'b1;
               error_term_in = err_minor[ERR_BITS-1:0];
            end else begin
               error_term_in = err_sum[ERR_BITS-1:0];
            end
         end
      end
   end

   always_comb begin
      pix_valid_in = pix_valid_ff;
      if (pix_load) begin
         pix_valid_in = emits;
      end
      pix_x_in     = sel_x_major ? sel_major : sel_minor;
      pix_y_in     = sel_x_major ? sel_minor : sel_major;
      pix_color_in = sel_color;
      pix_last_in  = sel_last;
   end

   always_comb begin
      addr_full   = pix_y_ff * width_ff + PROD_BITS'(pix_x_ff);
      out_addr_in = addr_full[ADDR_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= (COORD_BITS + 1)'(brl_pkg::WIDTH_RESET);
         busy_ff        <= 1'b0;
         cur_major_ff   <= '0;
         cur_minor_ff   <= '0;
         stop_major_ff  <= '0;
         delta_major_ff <= '0;
         delta_minor_ff <= '0;
         error_term_ff  <= '0;
         minor_down_ff  <= 1'b0;
         x_is_major_ff  <= 1'b0;
         held_color_ff  <= '0;
         pix_valid_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
         busy_ff        <= busy_in;
         cur_major_ff   <= cur_major_in;
         cur_minor_ff   <= cur_minor_in;
         stop_major_ff  <= stop_major_in;
         delta_major_ff <= delta_major_in;
         delta_minor_ff <= delta_minor_in;
         error_term_ff  <= error_term_in;
         minor_down_ff  <= minor_down_in;
         x_is_major_ff  <= x_is_major_in;
         held_color_ff  <= held_color_in;
         pix_valid_ff   <= pix_valid_in;
         if (out_load) begin
            out_valid_ff <= pix_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pix_load) begin
         pix_x_ff     <= pix_x_in;
         pix_y_ff     <= pix_y_in;
         pix_color_ff <= pix_color_in;
         pix_last_ff  <= pix_last_in;
      end
      if (out_load) begin
         out_x_ff     <= pix_x_ff;
         out_y_ff     <= pix_y_ff;
         out_addr_ff  <= out_addr_in;
         out_color_ff <= pix_color_ff;
         out_last_ff  <= pix_last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_x       = out_x_ff;
   assign rsp_pixel_y       = out_y_ff;
   assign rsp_pixel_address = out_addr_ff;
   assign rsp_pixel_color   = out_color_ff;
   assign rsp_last_pixel    = out_last_ff;

   // emitting the final endpoint ends the line
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (emits && sel_last) |=> !busy_ff)
      else $error("line still busy after its last pixel");

   // a running line never walks past its stop point
   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_major_ff <= stop_major_ff))
      else $error("major coordinate passed the stop point");

   // a step while idle leaves no item in the pixel stage
   a_idle_step_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_start && !busy_ff) |=> !pix_valid_ff)
      else $error("step while idle produced a pixel");

   // every result comes out of the pixel stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pix_valid_ff))
      else $error("result without a pixel stage item");

endmodule
